// File: design/text_terminal_cursor_engine_macros.svh
// Assertion macros for the text terminal cursor engine checker.
// Included by the checker file only; depends on nothing else.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define TTCE_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define TTCE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define TTCE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ttce_pkg;

    // Default screen geometry and tab spacing.
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 4;

    // Operation codes carried by an item.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Control characters and the blank glyph.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input item
        logic decode;     // apply cursor moves of control characters, load glyph count
        logic init_wr;    // write zero at the sweep address (reset clearing pass)
        logic clear_wr;   // write a blank at the sweep address
        logic scroll_wr;  // write a blank into the row leaving the top of the screen
        logic glyph_wr;   // write a glyph at the cursor and advance it
        logic bs_wr;      // write a blank at the cursor
        logic read_en;    // read the requested cell
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_put;
        logic is_read;
        logic is_clear;
        logic ch_nl;
        logic ch_cr;
        logic ch_bs;
        logic at_last_row;   // cursor on the bottom visible row
        logic glyph_scroll;  // next glyph wraps off the bottom row
        logic cnt_one;       // one glyph left to write
        logic cnt_zero;      // no glyph left to write
        logic sweep_last;    // sweep address at the last cell
        logic scol_last;     // scroll clear at the last column
    } stat_t;

endpackage

// File: design/ttce_ctrl.sv
// Controller state machine of the text terminal cursor engine.
// Depends on ttce_pkg for the command and status structures.
module ttce_ctrl
    import ttce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_GLYPH  = 9'b000001000,
        S_BSWR   = 9'b000010000,
        S_SCROLL = 9'b000100000,
        S_CLEAR  = 9'b001000000,
        S_READ   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // New items are taken when idle or while the previous result is shown.
    assign busy = !((state_reg == S_IDLE) || (state_reg == S_DONE));
    assign done = (state_reg == S_DONE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.latch  = start && !busy;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                priority if (stat.is_put)
                begin
                    priority if (stat.ch_nl)
                    begin
                        state_next = stat.at_last_row ? S_SCROLL : S_DONE;
                    end
                    else if (stat.ch_cr)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.ch_bs)
                    begin
                        state_next = S_BSWR;
                    end
                    else
                    begin
                        state_next = S_GLYPH;
                    end
                end
                else if (stat.is_read)
                begin
                    state_next = S_READ;
                end
                else if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_GLYPH:
            begin
                cmd.glyph_wr = 1'b1;
                priority if (stat.glyph_scroll)
                begin
                    state_next = S_SCROLL;
                end
                else if (stat.cnt_one)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GLYPH;
                end
            end
            S_BSWR:
            begin
                cmd.bs_wr  = 1'b1;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll_wr = 1'b1;
                if (stat.scol_last)
                begin
                    state_next = stat.cnt_zero ? S_DONE : S_GLYPH;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = S_DONE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // State register; reset starts the clearing pass over the screen store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/ttce_datapath.sv
// Datapath of the text terminal cursor engine: screen store, cursor, ring
// top row pointer and sweep counters. Depends on ttce_pkg.
module ttce_datapath
    import ttce_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic [15:0] cell_value,
    output logic [6:0]  current_column,
    output logic [4:0]  current_row
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int NW    = $clog2(TAB_WIDTH + 1);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [PW-1:0] PH_LAST   = PW'(TAB_WIDTH - 1);
    localparam logic [PW-1:0] PH_EDGE   = PW'((COLUMNS - 1) % TAB_WIDTH);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

    // Screen store and read data.
    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;

    // Latched item.
    logic [1:0]    op_reg;
    logic [7:0]    char_reg;
    logic [7:0]    attr_reg;
    logic [4:0]    rrow_reg;
    logic [6:0]    rcol_reg;
    logic          rd_valid_reg;

    // Cursor, tab phase, glyph count, ring pointer and sweep counters.
    logic [CW-1:0] col_reg,   col_next;
    logic [RW-1:0] row_reg,   row_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [NW-1:0] cnt_reg,   cnt_next;
    logic [RW-1:0] top_reg,   top_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] scol_reg,  scol_next;

    logic          ch_nl, ch_cr, ch_bs, ch_tab;
    logic          col_last, row_last, top_last;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [AW-1:0] cursor_addr;
    logic [15:0]   wdata;
    logic          rd_ok;

    // Physical row of a visible row: a ring offset by the top row pointer.
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] vrow);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, vrow};
        if (sum >= ROWS_W)
        begin
            sum = sum - ROWS_W;
        end
        return sum[RW-1:0];
    endfunction

    // Address of the first cell of a physical row.
    function automatic logic [AW-1:0] row_base(input logic [RW-1:0] prow);
        return AW'(prow) * COLS_A;
    endfunction

    // Character classes of the latched item.
    assign ch_nl  = (char_reg == CH_NEWLINE);
    assign ch_cr  = (char_reg == CH_RETURN);
    assign ch_bs  = (char_reg == CH_BACKSPACE);
    assign ch_tab = (char_reg == CH_TAB);

    assign col_last = (col_reg == COL_LAST);
    assign row_last = (row_reg == ROW_LAST);
    assign top_last = (top_reg == ROW_LAST);

    // Status towards the controller.
    always_comb
    begin
        stat.is_put       = (op_reg == OP_PUT);
        stat.is_read      = (op_reg == OP_READ);
        stat.is_clear     = (op_reg == OP_CLEAR);
        stat.ch_nl        = ch_nl;
        stat.ch_cr        = ch_cr;
        stat.ch_bs        = ch_bs;
        stat.at_last_row  = row_last;
        stat.glyph_scroll = col_last && row_last;
        stat.cnt_one      = (cnt_reg == NW'(1));
        stat.cnt_zero     = (cnt_reg == '0);
        stat.sweep_last   = (sweep_reg == CELL_LAST);
        stat.scol_last    = (scol_reg == COL_LAST);
    end

    // A read is in range only when both coordinates fall on the screen.
    assign rd_ok = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);

    // Cell addresses for the cursor and for the requested read.
    assign cursor_addr = row_base(phys_row(top_reg, row_reg)) + AW'(col_reg);
    assign raddr       = row_base(phys_row(top_reg, RW'(rrow_reg))) + AW'(rcol_reg);

    // Cursor, counters and ring pointer updates.
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        sweep_next = sweep_reg;
        scol_next  = scol_reg;

        // Newline, return and backspace move the cursor at once; glyphs and tabs are counted.
        if (cmd.decode && stat.is_put)
        begin
            priority if (ch_nl)
            begin
                col_next   = '0;
                phase_next = '0;
                if (!row_last)
                begin
                    row_next = row_reg + RW'(1);
                end
                cnt_next = '0;
            end
            else if (ch_cr)
            begin
                col_next   = '0;
                phase_next = '0;
                cnt_next   = '0;
            end
            else if (ch_bs)
            begin
                if (col_reg != '0)
                begin
                    col_next   = col_reg - CW'(1);
                    phase_next = (phase_reg == '0) ? PH_LAST : phase_reg - PW'(1);
                end
                else if (row_reg != '0)
                begin
                    row_next   = row_reg - RW'(1);
                    col_next   = COL_LAST;
                    phase_next = PH_EDGE;
                end
                cnt_next = '0;
            end
            else if (ch_tab)
            begin
                cnt_next = NW'(TAB_WIDTH) - NW'(phase_reg);
            end
            else
            begin
                cnt_next = NW'(1);
            end
        end

        // A glyph advances the cursor, wrapping at the right edge.
        if (cmd.glyph_wr)
        begin
            cnt_next = cnt_reg - NW'(1);
            if (col_last)
            begin
                col_next   = '0;
                phase_next = '0;
                if (!row_last)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next   = col_reg + CW'(1);
                phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + PW'(1);
            end
        end

        // Linear sweep over the whole store.
        if (cmd.init_wr || cmd.clear_wr)
        begin
            sweep_next = stat.sweep_last ? '0 : sweep_reg + AW'(1);
        end

        // Scroll clears the top row, then the ring pointer moves on.
        if (cmd.scroll_wr)
        begin
            scol_next = stat.scol_last ? '0 : scol_reg + CW'(1);
            if (stat.scol_last)
            begin
                top_next = top_last ? '0 : top_reg + RW'(1);
            end
        end
    end

    // Write port selection.
    always_comb
    begin
        we    = cmd.init_wr || cmd.clear_wr || cmd.scroll_wr || cmd.glyph_wr
                || cmd.bs_wr;
        waddr = cursor_addr;
        wdata = {attr_reg, CH_SPACE};
        priority if (cmd.init_wr)
        begin
            waddr = sweep_reg;
            wdata = '0;
        end
        else if (cmd.clear_wr)
        begin
            waddr = sweep_reg;
        end
        else if (cmd.scroll_wr)
        begin
            waddr = row_base(top_reg) + AW'(scol_reg);
        end
        else if (cmd.glyph_wr)
        begin
            wdata = {attr_reg, ch_tab ? CH_SPACE : char_reg};
        end
        else
        begin
            waddr = cursor_addr;
        end
    end

    // Screen store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.read_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Latched item fields.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            char_reg <= char_code;
            attr_reg <= attribute;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            top_reg      <= '0;
            sweep_reg    <= '0;
            scol_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            sweep_reg <= sweep_next;
            scol_reg  <= scol_next;
            if (cmd.latch)
            begin
                rd_valid_reg <= (opcode == OP_READ) && rd_ok;
            end
        end
    end

    // Result fields.
    assign cell_value     = rd_valid_reg ? rdata_reg : 16'h0000;
    assign current_column = 7'(col_reg);
    assign current_row    = 5'(row_reg);

endmodule

// File: design/text_terminal_cursor_engine.sv
// Top level of the text terminal cursor engine.
// Instantiates ttce_ctrl and ttce_datapath; depends on ttce_pkg.
//
//   Channel   Handshake          Fields
//   --------  -----------------  ------------------------------------------
//   item in   start, busy        opcode, char_code, attribute, read_row,
//                                read_col
//   result    done (one cycle)   cell_value, current_column, current_row
//
// After reset the screen store is cleared one cell a cycle, with busy high
// throughout.
// From accept to the next possible accept, a newline or carriage return
// passes through decode alone; a glyph, backspace or read adds one write
// or read state, a tab one glyph write per space, a scroll a sweep of one
// row, and clear screen a sweep of the whole store; all use one write port.
// The result receiver cannot stall; a new item may be taken in the cycle
// that shows the previous result.
module text_terminal_cursor_engine
    import ttce_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        done,
    output logic [15:0] cell_value,
    output logic [6:0]  current_column,
    output logic [4:0]  current_row
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer for the item cases, scrolling and sweeps.
    ttce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Screen store, cursor and counters.
    ttce_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .char_code      (char_code),
        .attribute      (attribute),
        .read_row       (read_row),
        .read_col       (read_col),
        .cell_value     (cell_value),
        .current_column (current_column),
        .current_row    (current_row)
    );

endmodule

// File: design/ttce_checker.sv
// Port-level checker for the text terminal cursor engine, bound to the top.
// Depends on text_terminal_cursor_engine_macros.svh and ttce_pkg.
`include "text_terminal_cursor_engine_macros.svh"

module ttce_checker
    import ttce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [6:0] current_column,
    input logic [4:0] current_row
);

    // The cursor always lies on the screen.
    `TTCE_ASSERT_ALWAYS(a_cursor_range, clk, rst_n, (int'(current_column) < COLUMNS) && (int'(current_row) < ROWS), "cursor off screen")

    // A result is shown for one cycle only.
    `TTCE_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held")

    // No result in the cycle straight after an item is taken.
    `TTCE_ASSERT_NEXT(a_no_early_done, clk, rst_n, start && !busy, !done, "result too early")

    // With no item taken, the cursor stays where it is.
    `TTCE_ASSERT_NEXT(a_idle_stable, clk, rst_n, !busy && !start, $stable(current_column) && $stable(current_row), "cursor moved while idle")

    // The engine is ready while it shows a result.
    `TTCE_ASSERT_SAME(a_done_ready, clk, rst_n, done, !busy, "busy during result")

endmodule

bind text_terminal_cursor_engine ttce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .current_column (current_column),
    .current_row    (current_row)
);

// File: tb/text_terminal_cursor_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text terminal cursor engine: text, control characters,
// reads and screen clears are checked against a screen predictor kept in the bench.
// Depends on ttce_pkg and the text_terminal_cursor_engine top level.
module text_terminal_cursor_engine_tb;
    import ttce_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int ROWS         = ROWS_DEF;
    localparam int TAB_WIDTH    = TAB_WIDTH_DEF;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 360;
    localparam int STALL_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } terminal_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  column;
        logic [4:0]  row;
    } cursor_report_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
    logic        done;
    logic [15:0] cell_value;
    logic [6:0]  current_column;
    logic [4:0]  current_row;

    // Shadow copy of the screen store, cursor and ring pointer.
    logic [15:0] shadow_cells [CELLS];
    int shadow_col;
    int shadow_row;
    int shadow_top;

    cursor_report_t expected_reports [$];

    int items_sent;
    int directed_items;
    int results_checked;
    int error_count;
    int idle_cycles;
    int put_count;
    int read_count;
    int clear_count;
    int scroll_count;

    text_terminal_cursor_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .char_code      (char_code),
        .attribute      (attribute),
        .read_row       (read_row),
        .read_col       (read_col),
        .done           (done),
        .cell_value     (cell_value),
        .current_column (current_column),
        .current_row    (current_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Screen predictor
    // ------------------------------------------------------------------

    function automatic int screen_index(int vrow, int col);
        return ((shadow_top + vrow) % ROWS) * COLUMNS + col;
    endfunction

    // The top physical row becomes the new bottom row, filled with blanks.
    function automatic void scroll_screen(logic [7:0] attr);
        for (int c = 0; c < COLUMNS; c++)
            shadow_cells[shadow_top * COLUMNS + c] = {attr, CH_SPACE};
        shadow_top = (shadow_top + 1) % ROWS;
        if (shadow_row > 0)
            shadow_row--;
        scroll_count++;
    endfunction

    function automatic void settle_cursor(logic [7:0] attr);
        if (shadow_col >= COLUMNS)
        begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS)
            scroll_screen(attr);
    endfunction

    function automatic void write_glyph(logic [7:0] ch, logic [7:0] attr);
        shadow_cells[screen_index(shadow_row, shadow_col)] = {attr, ch};
        shadow_col++;
        settle_cursor(attr);
    endfunction

    function automatic void apply_character(logic [7:0] ch, logic [7:0] attr);
        int spaces;
        unique case (ch)
            CH_NEWLINE:
            begin
                shadow_col = 0;
                shadow_row++;
                settle_cursor(attr);
            end
            CH_RETURN:
            begin
                shadow_col = 0;
                settle_cursor(attr);
            end
            CH_BACKSPACE:
            begin
                // Back one column, up to the end of the row above at column zero,
                // and no move at all from the top-left corner.
                if (shadow_col > 0)
                    shadow_col--;
                else if (shadow_row > 0)
                begin
                    shadow_row--;
                    shadow_col = COLUMNS - 1;
                end
                shadow_cells[screen_index(shadow_row, shadow_col)] = {attr, CH_SPACE};
                settle_cursor(attr);
            end
            CH_TAB:
            begin
                spaces = TAB_WIDTH - (shadow_col % TAB_WIDTH);
                repeat (spaces) write_glyph(CH_SPACE, attr);
                settle_cursor(attr);
            end
            default:
                write_glyph(ch, attr);
        endcase
    endfunction

    function automatic cursor_report_t predict_report(terminal_item_t it);
        cursor_report_t rep;
        rep.cell_data = '0;
        unique case (it.opcode)
            OP_PUT:
            begin
                apply_character(it.char_code, it.attribute);
                put_count++;
            end
            OP_READ:
            begin
                if (it.read_row < ROWS && it.read_col < COLUMNS)
                    rep.cell_data = shadow_cells[screen_index(it.read_row, it.read_col)];
                read_count++;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = {it.attribute, CH_SPACE};
                clear_count++;
            end
            default: ;
        endcase
        rep.column = 7'(shadow_col);
        rep.row    = 5'(shadow_row);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Item driving
    // ------------------------------------------------------------------

    function automatic terminal_item_t make_item(logic [1:0] op, logic [7:0] ch,
                                                 logic [7:0] attr, logic [4:0] row,
                                                 logic [6:0] col);
        terminal_item_t it;
        it.opcode    = op;
        it.char_code = ch;
        it.attribute = attr;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    // Presents one item and holds it until the block takes it.
    task automatic send_item(input terminal_item_t it);
        @(negedge clk);
        opcode    = it.opcode;
        char_code = it.char_code;
        attribute = it.attribute;
        read_row  = it.read_row;
        read_col  = it.read_col;
        start     = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_reports.push_back(predict_report(it));
        items_sent++;
    endtask

    task automatic send_put(input logic [7:0] ch, input logic [7:0] attr);
        send_item(make_item(OP_PUT, ch, attr, 5'd0, 7'd0));
    endtask

    task automatic send_read(input logic [4:0] row, input logic [6:0] col);
        send_item(make_item(OP_READ, 8'h00, 8'h00, row, col));
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    task automatic test_control_characters();
        send_put(CH_BACKSPACE, 8'h5A);      // top-left corner: cursor stays
        send_put(8'hFF, 8'hFF);
        send_put(8'h00, 8'h00);
        send_put(CH_TAB, 8'h3C);            // column two: two spaces
        send_put(CH_TAB, 8'hC3);            // column four: a full tab
        send_put(CH_RETURN, 8'h11);
        send_put(CH_NEWLINE, 8'h22);
        send_put(CH_BACKSPACE, 8'h81);      // column zero: back to the row above
        send_put(8'h41, 8'h17);             // last column: wraps to the next row
    endtask

    task automatic test_cell_reads();
        send_read(5'd0, 7'd0);
        send_read(5'd0, 7'd1);
        send_read(5'd0, 7'd79);
        send_read(5'd24, 7'd79);
        send_read(5'd31, 7'd0);             // row out of range
        send_read(5'd0, 7'd127);            // column out of range
        send_read(5'd25, 7'd80);
    endtask

    task automatic test_spare_opcode();
        send_item(make_item(OP_SPARE, 8'hFF, 8'hFF, 5'd31, 7'd127));
        send_read(5'd0, 7'd2);
    endtask

    task automatic test_clear_screen();
        send_item(make_item(OP_CLEAR, 8'h00, 8'hA5, 5'd0, 7'd0));
        send_read(5'd1, 7'd0);
        send_read(5'd24, 7'd79);
    endtask

    // ------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------

    function automatic terminal_item_t random_item();
        terminal_item_t it;
        int pick;
        it.opcode    = OP_PUT;
        it.char_code = 8'($urandom);
        it.attribute = 8'($urandom);
        it.read_row  = 5'($urandom);
        it.read_col  = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.char_code = 8'($urandom_range(8'h21, 8'h7E));
        else if (pick < 52)
            it.char_code = CH_NEWLINE;
        else if (pick < 56)
            it.char_code = CH_RETURN;
        else if (pick < 63)
            it.char_code = CH_BACKSPACE;
        else if (pick < 70)
            it.char_code = CH_TAB;
        else if (pick < 78)
            it.opcode = OP_PUT;             // any byte at all
        else if (pick < 95)
        begin
            it.opcode = OP_READ;
            if (pick < 92)
            begin
                it.read_row = 5'($urandom_range(0, ROWS - 1));
                it.read_col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (pick < 96)
            it.opcode = OP_CLEAR;
        else
            it.opcode = OP_SPARE;
        return it;
    endfunction

    // A line of 30 to 100 printable characters, which may wrap, ended by a newline or a return.
    task automatic send_text_line();
        int length;
        logic [7:0] attr;
        length = $urandom_range(30, 100);
        attr   = 8'($urandom);
        repeat (length) send_put(8'($urandom_range(8'h20, 8'h7E)), attr);
        send_put($urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, attr);
    endtask

    task automatic test_random_text();
        int kind;
        int burst_len;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_text_line();
            else if (kind == 1)
                repeat ($urandom_range(5, 30)) send_put(CH_NEWLINE, 8'($urandom));
            else
            begin
                burst_len = $urandom_range(3, 20);
                repeat (burst_len)
                begin
                    send_item(random_item());
                    if ($urandom_range(0, 3) == 0)
                        pause_sender($urandom_range(1, 3));
                end
            end
            // Between bursts the sender either runs on, idles, or waits for the block to empty.
            if (kind == 9)
                wait_drained();
            else if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cursor_report_t want;
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("Result with no item outstanding: cell %h col %0d row %0d",
                             cell_value, current_column, current_row);
            end
            else
            begin
                want = expected_reports.pop_front();
                results_checked++;
                if (cell_value !== want.cell_data || current_column !== want.column ||
                    current_row !== want.row)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("Mismatch on result %0d: cell %h/%h col %0d/%0d row %0d/%0d",
                                 results_checked, want.cell_data, cell_value, want.column,
                                 current_column, want.row, current_row);
                end
            end
        end
    end

    // Ends the run if nothing is taken or returned for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item taken and no result for %0d cycles", STALL_LIMIT);
                $display("text_terminal_cursor_engine_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = OP_PUT;
        char_code = 8'h00;
        attribute = 8'h00;
        read_row  = 5'd0;
        read_col  = 7'd0;
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = 16'h0000;
        shadow_col      = 0;
        shadow_row      = 0;
        shadow_top      = 0;
        items_sent      = 0;
        results_checked = 0;
        error_count     = 0;
        idle_cycles     = 0;
        put_count       = 0;
        read_count      = 0;
        clear_count     = 0;
        scroll_count    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_control_characters();
        test_cell_reads();
        test_spare_opcode();
        test_clear_screen();
        directed_items = items_sent;
        test_random_text();

        // Let the last results arrive, then watch a little longer for strays.
        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_reports.size() != 0)
            error_count++;

        $display("Sent %0d items (%0d puts, %0d reads, %0d clears), %0d scrolls predicted.",
                 items_sent, put_count, read_count, clear_count, scroll_count);
        $display("Checked %0d results, %0d failures.", results_checked, error_count);
        if (error_count == 0)
            $display("text_terminal_cursor_engine_tb: PASS");
        else
            $display("text_terminal_cursor_engine_tb: FAIL");
        $finish;
    end

endmodule
